FILE: design/zip_pkg.sv
// ----------------------------------------------------------------------------
// zip_pkg
// Shared types, register indexes and helpers for the z intensity projection.
// ----------------------------------------------------------------------------
package zip_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  // Gray samples keep this many low bits.
  localparam int          SAMPLE_BITS = 16;
  localparam logic [15:0] GRAY_MASK   = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

  localparam int          MAX_SLICES  = 4096;
  localparam int          STORE_BITS  = 24;

  localparam int          CFG_IDX_BITS  = 3;
  localparam int          CFG_DATA_BITS = 13;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLICE_COUNT     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PROJECTION_MODE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_FORMAT    = 3'd4;

  typedef struct packed {
    logic [9:0]  frame_width;
    logic [9:0]  frame_height;
    logic [12:0] slice_count;
    logic        projection_mode;
    logic        pixel_format;
  } zip_cfg_t;

  // Per-voxel control and payload carried down the pipeline.
  typedef struct packed {
    logic [STORE_BITS-1:0] voxel;
    logic                  first_slice;
    logic                  emit;
    logic                  done;
    logic [8:0]            x;
    logic [8:0]            y;
    logic                  keep_min;
    logic                  rgb;
  } zip_item_t;

  function automatic logic [15:0] zip_pick(input logic [15:0] a, input logic [15:0] b,
                                           input logic keep_min);
    logic a_less;
    a_less = a < b;
    if (keep_min) begin
      return a_less ? a : b;
    end
    return a_less ? b : a;
  endfunction

endpackage

FILE: design/z_intensity_projection.sv
// ----------------------------------------------------------------------------
// z_intensity_projection
// Streaming maximum/minimum intensity projection along z.
// ----------------------------------------------------------------------------
// Takes one voxel per clock in raster order (x fastest, then y, then slice)
// and sustains one voxel per cycle as long as out_ready is high. A voxel goes
// through three register stages: position counters and address, frame store
// read, then merge into the output register, so a projected pixel moves
// via s1, s2 and the output register after its last-slice voxel. The frame
// store is a single MAX_WIDTH*MAX_HEIGHT x 24-bit memory with one read and
// one write per cycle; the first slice overwrites every entry in the frame,
// so there is no clearing pass after reset. The whole pipeline holds while a
// result waits on out_ready.
// ----------------------------------------------------------------------------
module z_intensity_projection import zip_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [15:0]              gray_or_red,
  input  logic [7:0]               green_sample,
  input  logic [7:0]               blue_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [15:0]              proj_gray_or_red,
  output logic [7:0]               proj_green,
  output logic [7:0]               proj_blue,
  output logic [8:0]               pixel_x,
  output logic [8:0]               pixel_y,
  output logic                     frame_done
);

  localparam int AW = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;

  zip_cfg_t              cfg;
  logic                  adv;
  logic                  s1_valid;
  logic [AW-1:0]         s1_addr;
  zip_item_t             s1_item;
  logic                  s2_valid;
  zip_item_t             s2_item;
  logic [STORE_BITS-1:0] s2_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width     <= 10'd512;
      cfg.frame_height    <= 10'd512;
      cfg.slice_count     <= 13'd1;
      cfg.projection_mode <= 1'b0;
      cfg.pixel_format    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:     cfg.frame_width     <= cfg_data[9:0];
        REG_FRAME_HEIGHT:    cfg.frame_height    <= cfg_data[9:0];
        REG_SLICE_COUNT:     cfg.slice_count     <= cfg_data;
        REG_PROJECTION_MODE: cfg.projection_mode <= cfg_data[0];
        REG_PIXEL_FORMAT:    cfg.pixel_format    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance everything unless a finished beat is still waiting.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  zip_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (in_valid),
    .gray_or_red  (gray_or_red),
    .green_sample (green_sample),
    .blue_sample  (blue_sample),
    .cfg          (cfg),
    .s1_valid     (s1_valid),
    .s1_addr      (s1_addr),
    .s1_item      (s1_item)
  );

  zip_merge #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1_addr   (s1_addr),
    .s1_item   (s1_item),
    .s2_valid  (s2_valid),
    .s2_item   (s2_item),
    .s2_result (s2_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid && s2_item.emit;
    end
  end

  // Drop silent beats: only last-slice pixels load the output register.
  always_ff @(posedge clk) begin
    if (adv && s2_valid && s2_item.emit) begin
      proj_gray_or_red <= s2_item.rgb ? {8'd0, s2_result[7:0]} : s2_result[15:0];
      proj_green       <= s2_item.rgb ? s2_result[15:8] : 8'd0;
      proj_blue        <= s2_item.rgb ? s2_result[23:16] : 8'd0;
      pixel_x          <= s2_item.x;
      pixel_y          <= s2_item.y;
      frame_done       <= s2_item.done;
    end
  end

endmodule

FILE: design/zip_ctrl.sv
// ----------------------------------------------------------------------------
// zip_ctrl
// Raster position counters, voxel packing and frame store address; first
// pipeline register.
// ----------------------------------------------------------------------------
module zip_ctrl import zip_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int AW         = 18
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [15:0]     gray_or_red,
  input  logic [7:0]      green_sample,
  input  logic [7:0]      blue_sample,
  input  zip_cfg_t        cfg,
  output logic            s1_valid,
  output logic [AW-1:0]   s1_addr,
  output zip_item_t       s1_item
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XW = (CW >= 10) ? CW + 1 : 11;
  localparam int YW = (RW >= 10) ? RW + 1 : 11;

  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [11:0]   slice_index, slice_index_next;

  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;
  logic [12:0]   n_eff;
  logic          last_col, last_row, last_slice;
  logic          accept;
  zip_item_t     item;
  logic [AW-1:0] addr;

  assign accept = in_valid && adv;

  // Clamp the frame size and slice count into their legal ranges.
  always_comb begin
    if (cfg.frame_width == 10'd0) begin
      w_eff = XW'(1);
    end else if (XW'(cfg.frame_width) > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(cfg.frame_width);
    end
    if (cfg.frame_height == 10'd0) begin
      h_eff = YW'(1);
    end else if (YW'(cfg.frame_height) > YW'(MAX_HEIGHT)) begin
      h_eff = YW'(MAX_HEIGHT);
    end else begin
      h_eff = YW'(cfg.frame_height);
    end
    if (cfg.slice_count == 13'd0) begin
      n_eff = 13'd1;
    end else if (cfg.slice_count > 13'(MAX_SLICES)) begin
      n_eff = 13'(MAX_SLICES);
    end else begin
      n_eff = cfg.slice_count;
    end
  end

  assign last_col   = XW'(column_count) >= (w_eff - XW'(1));
  assign last_row   = YW'(row_count) >= (h_eff - YW'(1));
  assign last_slice = {1'b0, slice_index} >= (n_eff - 13'd1);

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    slice_index_next  = slice_index;
    if (last_col) begin
      column_count_next = '0;
      if (last_row) begin
        row_count_next   = '0;
        slice_index_next = last_slice ? 12'd0 : slice_index + 12'd1;
      end else begin
        row_count_next = row_count + RW'(1);
      end
    end else begin
      column_count_next = column_count + CW'(1);
    end
  end

  always_comb begin
    item.voxel       = cfg.pixel_format ? {blue_sample, green_sample, gray_or_red[7:0]}
                                        : {8'd0, gray_or_red & GRAY_MASK};
    item.first_slice = slice_index == 12'd0;
    item.emit        = last_slice;
    item.done        = last_col && last_row;
    item.x           = 9'(column_count);
    item.y           = 9'(row_count);
    item.keep_min    = cfg.projection_mode;
    item.rgb         = cfg.pixel_format;
  end

  assign addr = AW'(AW'(row_count) * AW'(MAX_WIDTH)) + AW'(column_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      slice_index  <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        slice_index  <= slice_index_next;
      end
      if (adv) begin
        s1_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr <= addr;
      s1_item <= item;
    end
  end

endmodule

FILE: design/zip_merge.sv
// ----------------------------------------------------------------------------
// zip_merge
// Frame store with registered read, write-to-read forwarding and the per
// channel max/min merge.
// ----------------------------------------------------------------------------
module zip_merge import zip_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int AW         = 18
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  s1_valid,
  input  logic [AW-1:0]         s1_addr,
  input  zip_item_t             s1_item,
  output logic                  s2_valid,
  output zip_item_t             s2_item,
  output logic [STORE_BITS-1:0] s2_result
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  logic [STORE_BITS-1:0] frame_store [DEPTH];
  logic [STORE_BITS-1:0] rd_data;
  logic [AW-1:0]         s2_addr;
  logic                  fwd_hit;
  logic [STORE_BITS-1:0] fwd_data;
  logic [STORE_BITS-1:0] stored;
  logic [15:0]           gray, red, green, blue;

  // The beat leaving this stage writes on the same edge the next one reads.
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= frame_store[s1_addr];
      if (s2_valid) begin
        frame_store[s2_addr] <= s2_result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_addr  <= s1_addr;
      s2_item  <= s1_item;
      fwd_hit  <= s2_valid && (s2_addr == s1_addr);
      fwd_data <= s2_result;
    end
  end

  assign stored = fwd_hit ? fwd_data : rd_data;

  always_comb begin
    gray  = zip_pick(stored[15:0] & GRAY_MASK, s2_item.voxel[15:0], s2_item.keep_min);
    red   = zip_pick({8'd0, stored[7:0]}, {8'd0, s2_item.voxel[7:0]}, s2_item.keep_min);
    green = zip_pick({8'd0, stored[15:8]}, {8'd0, s2_item.voxel[15:8]}, s2_item.keep_min);
    blue  = zip_pick({8'd0, stored[23:16]}, {8'd0, s2_item.voxel[23:16]}, s2_item.keep_min);
    if (s2_item.first_slice) begin
      s2_result = s2_item.voxel;
    end else if (s2_item.rgb) begin
      s2_result = {blue[7:0], green[7:0], red[7:0]};
    end else begin
      s2_result = {8'd0, gray};
    end
  end

endmodule
